### sv/dihed_pkg.sv
// ----------------------------------------------------------------------------
// dihed_pkg
// shared widths, types and register codes of the dihedral angle pipeline
// ----------------------------------------------------------------------------
package dihed_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int MAG_W     = 33;
    localparam int SCL_W     = 15;
    localparam int SCL_MSB   = 13;
    localparam int SCL_SH_W  = 5;
    localparam int PROD_W    = 30;
    localparam int NRM_W     = 31;
    localparam int SQ_W      = 30;
    localparam int X_W       = 64;
    localparam int T_W       = 48;
    localparam int HALF_W    = 24;
    localparam int RT_STEPS  = 15;
    localparam int RT_W      = 31;
    localparam int RG_W      = 15;
    localparam int CD_W      = 35;
    localparam int Z_W       = 27;
    localparam int NORM_MSB  = 29;
    localparam int NRM_SH_W  = 6;
    localparam int CD_STEPS  = 23;
    localparam int ANG_W     = 17;
    localparam int BOX_W     = 32;
    localparam int AXES_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic signed [Z_W-1:0]   DEG180_Q16  = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 17'sd46080;
    localparam logic [BOX_W-1:0]        BOX_RESET   = 32'd6553600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X = 2'd0,
        REG_BOX_Y = 2'd1,
        REG_BOX_Z = 2'd2,
        REG_AXES  = 2'd3
    } cfg_reg_e;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [SCL_W-1:0]   scl_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        point_t p1;
        point_t p2;
        point_t p3;
        point_t p4;
    } pts_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
        diff_t z;
    } dvec_t;

    typedef struct packed {
        scl_t x;
        scl_t y;
        scl_t z;
    } svec_t;

    typedef struct packed {
        logic [BOX_W-1:0]  box_x;
        logic [BOX_W-1:0]  box_y;
        logic [BOX_W-1:0]  box_z;
        logic [AXES_W-1:0] axes;
    } box_cfg_t;

endpackage

### sv/dihed_pts_if.sv
// ----------------------------------------------------------------------------
// dihed_pts_if
// input channel carrying the four positions of one torsion
// ----------------------------------------------------------------------------
interface dihed_pts_if;
    logic valid;
    logic ready;
    dihed_pkg::coord_t p1_x;
    dihed_pkg::coord_t p1_y;
    dihed_pkg::coord_t p1_z;
    dihed_pkg::coord_t p2_x;
    dihed_pkg::coord_t p2_y;
    dihed_pkg::coord_t p2_z;
    dihed_pkg::coord_t p3_x;
    dihed_pkg::coord_t p3_y;
    dihed_pkg::coord_t p3_z;
    dihed_pkg::coord_t p4_x;
    dihed_pkg::coord_t p4_y;
    dihed_pkg::coord_t p4_z;

    modport source (
        output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
        output p3_x, p3_y, p3_z, p4_x, p4_y, p4_z,
        input  ready
    );
    modport sink (
        input  valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
        input  p3_x, p3_y, p3_z, p4_x, p4_y, p4_z,
        output ready
    );
endinterface

### sv/dihed_angle_if.sv
// ----------------------------------------------------------------------------
// dihed_angle_if
// output channel carrying one signed angle word
// ----------------------------------------------------------------------------
interface dihed_angle_if;
    logic valid;
    logic ready;
    logic signed [dihed_pkg::ANG_W-1:0] angle_deg;

    modport source (
        output valid, angle_deg,
        input  ready
    );
    modport sink (
        input  valid, angle_deg,
        output ready
    );
endinterface

### sv/dihed_cfg_if.sv
// ----------------------------------------------------------------------------
// dihed_cfg_if
// register write channel, index and data
// ----------------------------------------------------------------------------
interface dihed_cfg_if;
    logic valid;
    logic ready;
    logic [dihed_pkg::CFG_IDX_W-1:0] index;
    logic [dihed_pkg::CFG_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### sv/dihed_vec.sv
// ----------------------------------------------------------------------------
// dihed_vec
// bond vectors, minimum image wrap and shared block scaling, six stages
// ----------------------------------------------------------------------------
module dihed_vec (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  dihed_pkg::pts_t      pts,
    input  dihed_pkg::box_cfg_t  cfg,
    output logic                 out_valid,
    output dihed_pkg::svec_t     b1,
    output dihed_pkg::svec_t     b2,
    output dihed_pkg::svec_t     b3
);

    localparam int NSTG = 6;

    function automatic logic [dihed_pkg::MAG_W-1:0] magn(input dihed_pkg::diff_t d);
        return d[dihed_pkg::DIFF_W-1] ? $unsigned(-d) : $unsigned(d);
    endfunction

    function automatic dihed_pkg::diff_t min_image(input dihed_pkg::diff_t d,
                                                   input logic [dihed_pkg::BOX_W-1:0] box,
                                                   input logic on);
        logic [dihed_pkg::MAG_W-1:0] m;
        logic signed [dihed_pkg::DIFF_W:0] w;
        m = magn(d);
        w = {d[dihed_pkg::DIFF_W-1], d};
        if (on && ({m, 1'b0} > {2'b00, box})) begin
            if (d[dihed_pkg::DIFF_W-1])
                w = w + $signed({2'b00, box});
            else
                w = w - $signed({2'b00, box});
        end
        return w[dihed_pkg::DIFF_W-1:0];
    endfunction

    function automatic dihed_pkg::dvec_t vsub(input dihed_pkg::point_t a,
                                              input dihed_pkg::point_t b);
        dihed_pkg::dvec_t r;
        r.x = dihed_pkg::diff_t'(a.x) - dihed_pkg::diff_t'(b.x);
        r.y = dihed_pkg::diff_t'(a.y) - dihed_pkg::diff_t'(b.y);
        r.z = dihed_pkg::diff_t'(a.z) - dihed_pkg::diff_t'(b.z);
        return r;
    endfunction

    function automatic dihed_pkg::dvec_t vmin(input dihed_pkg::dvec_t d,
                                              input dihed_pkg::box_cfg_t c);
        dihed_pkg::dvec_t r;
        r.x = min_image(d.x, c.box_x, c.axes[0]);
        r.y = min_image(d.y, c.box_y, c.axes[1]);
        r.z = min_image(d.z, c.box_z, c.axes[2]);
        return r;
    endfunction

    function automatic dihed_pkg::dvec_t vneg(input dihed_pkg::dvec_t d);
        dihed_pkg::dvec_t r;
        r.x = -d.x;
        r.y = -d.y;
        r.z = -d.z;
        return r;
    endfunction

    function automatic logic [dihed_pkg::MAG_W-1:0] vor(input dihed_pkg::dvec_t d);
        return magn(d.x) | magn(d.y) | magn(d.z);
    endfunction

    function automatic dihed_pkg::scl_t shrink(input dihed_pkg::diff_t d,
                                               input logic [dihed_pkg::SCL_SH_W-1:0] sh);
        logic [dihed_pkg::MAG_W-1:0] m;
        dihed_pkg::scl_t s;
        m = magn(d) >> sh;
        s = dihed_pkg::scl_t'({1'b0, m[dihed_pkg::SCL_W-2:0]});
        return d[dihed_pkg::DIFF_W-1] ? -s : s;
    endfunction

    function automatic dihed_pkg::svec_t vshrink(input dihed_pkg::dvec_t d,
                                                 input logic [dihed_pkg::SCL_SH_W-1:0] sh);
        dihed_pkg::svec_t r;
        r.x = shrink(d.x, sh);
        r.y = shrink(d.y, sh);
        r.z = shrink(d.z, sh);
        return r;
    endfunction

    logic [NSTG-1:0] vld_reg;

    dihed_pkg::dvec_t d1_reg, d2_reg, d3_reg;
    dihed_pkg::dvec_t w1_reg, w2_reg, w3_reg;
    dihed_pkg::dvec_t u1_reg, u2_reg, u3_reg;
    dihed_pkg::dvec_t k1_reg, k2_reg, k3_reg;
    dihed_pkg::dvec_t h1_reg, h2_reg, h3_reg;
    dihed_pkg::svec_t b1_reg, b2_reg, b3_reg;
    logic [dihed_pkg::MAG_W-1:0]    mor_reg;
    logic [dihed_pkg::SCL_SH_W-1:0] sh_reg;
    logic [dihed_pkg::SCL_SH_W-1:0] sh_next;

    // smallest shift that brings the largest magnitude under the scale limit
    always_comb
    begin
        sh_next = '0;
        for (int i = dihed_pkg::SCL_MSB + 1; i < dihed_pkg::MAG_W; i++)
        begin
            if (mor_reg[i])
                sh_next = dihed_pkg::SCL_SH_W'(i - dihed_pkg::SCL_MSB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= vsub(pts.p1, pts.p2);
            d2_reg <= vsub(pts.p3, pts.p2);
            d3_reg <= vsub(pts.p4, pts.p3);
            w1_reg <= vmin(d1_reg, cfg);
            w2_reg <= vmin(d2_reg, cfg);
            w3_reg <= vmin(d3_reg, cfg);
            u1_reg <= w1_reg;
            u2_reg <= vmin(vneg(w2_reg), cfg);
            u3_reg <= w3_reg;
            k1_reg <= u1_reg;
            k2_reg <= u2_reg;
            k3_reg <= u3_reg;
            mor_reg <= vor(u1_reg) | vor(u2_reg) | vor(u3_reg);
            h1_reg <= k1_reg;
            h2_reg <= k2_reg;
            h3_reg <= k3_reg;
            sh_reg <= sh_next;
            b1_reg <= vshrink(h1_reg, sh_reg);
            b2_reg <= vshrink(h2_reg, sh_reg);
            b3_reg <= vshrink(h3_reg, sh_reg);
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign b1 = b1_reg;
    assign b2 = b2_reg;
    assign b3 = b3_reg;

endmodule

### sv/dihed_cross.sv
// ----------------------------------------------------------------------------
// dihed_cross
// plane normals, their dot product, triple product and squared bond length
// ----------------------------------------------------------------------------
module dihed_cross (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  dihed_pkg::svec_t                      b1,
    input  dihed_pkg::svec_t                      b2,
    input  dihed_pkg::svec_t                      b3,
    output logic                                  out_valid,
    output logic signed [dihed_pkg::X_W-1:0]      x,
    output logic signed [dihed_pkg::T_W-1:0]      t,
    output logic [dihed_pkg::SQ_W-1:0]            n
);

    localparam int NSTG = 4;

    typedef logic signed [dihed_pkg::PROD_W-1:0]          prod_t;
    typedef logic signed [dihed_pkg::NRM_W-1:0]           nrm_t;
    typedef logic signed [2*dihed_pkg::NRM_W-1:0]         xp_t;
    typedef logic signed [dihed_pkg::NRM_W+dihed_pkg::SCL_W-1:0] tp_t;
    typedef logic signed [dihed_pkg::X_W-1:0]             x_t;
    typedef logic signed [dihed_pkg::T_W-1:0]             t_t;

    function automatic prod_t mul(input dihed_pkg::scl_t a, input dihed_pkg::scl_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    logic [NSTG-1:0] vld_reg;

    prod_t pa_reg [6];
    prod_t pb_reg [6];
    prod_t sq_reg [3];
    nrm_t  av_reg [3];
    nrm_t  bv_reg [3];
    xp_t   xp_reg [3];
    tp_t   tp_reg [3];
    dihed_pkg::svec_t c3_reg, e3_reg;
    logic [dihed_pkg::SQ_W-1:0] n8_reg, n9_reg, n_reg;
    x_t x_reg;
    t_t t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg[0] <= mul(b1.y, b2.z);
            pa_reg[1] <= mul(b1.z, b2.y);
            pa_reg[2] <= mul(b1.z, b2.x);
            pa_reg[3] <= mul(b1.x, b2.z);
            pa_reg[4] <= mul(b1.x, b2.y);
            pa_reg[5] <= mul(b1.y, b2.x);
            pb_reg[0] <= mul(b3.y, b2.z);
            pb_reg[1] <= mul(b3.z, b2.y);
            pb_reg[2] <= mul(b3.z, b2.x);
            pb_reg[3] <= mul(b3.x, b2.z);
            pb_reg[4] <= mul(b3.x, b2.y);
            pb_reg[5] <= mul(b3.y, b2.x);
            sq_reg[0] <= mul(b2.x, b2.x);
            sq_reg[1] <= mul(b2.y, b2.y);
            sq_reg[2] <= mul(b2.z, b2.z);
            c3_reg    <= b3;

            for (int i = 0; i < 3; i++)
            begin
                av_reg[i] <= nrm_t'(pa_reg[2*i]) - nrm_t'(pa_reg[2*i+1]);
                bv_reg[i] <= nrm_t'(pb_reg[2*i]) - nrm_t'(pb_reg[2*i+1]);
            end
            n8_reg <= $unsigned(sq_reg[0]) + $unsigned(sq_reg[1]) + $unsigned(sq_reg[2]);
            e3_reg <= c3_reg;

            for (int i = 0; i < 3; i++)
                xp_reg[i] <= xp_t'(av_reg[i]) * xp_t'(bv_reg[i]);
            tp_reg[0] <= tp_t'(av_reg[0]) * tp_t'(e3_reg.x);
            tp_reg[1] <= tp_t'(av_reg[1]) * tp_t'(e3_reg.y);
            tp_reg[2] <= tp_t'(av_reg[2]) * tp_t'(e3_reg.z);
            n9_reg <= n8_reg;

            x_reg <= x_t'(xp_reg[0]) + x_t'(xp_reg[1]) + x_t'(xp_reg[2]);
            t_reg <= t_t'(tp_reg[0]) + t_t'(tp_reg[1]) + t_t'(tp_reg[2]);
            n_reg <= n9_reg;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign x = x_reg;
    assign t = t_reg;
    assign n = n_reg;

endmodule

### sv/dihed_sqrt.sv
// ----------------------------------------------------------------------------
// dihed_sqrt
// pipelined integer square root, one root bit a stage, rounded to nearest
// ----------------------------------------------------------------------------
module dihed_sqrt (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [dihed_pkg::X_W-1:0]      x,
    input  logic signed [dihed_pkg::T_W-1:0]      t,
    input  logic [dihed_pkg::SQ_W-1:0]            n,
    output logic                                  out_valid,
    output logic signed [dihed_pkg::X_W-1:0]      x_out,
    output logic signed [dihed_pkg::T_W-1:0]      t_out,
    output logic [dihed_pkg::RG_W-1:0]            rg
);

    localparam int NS = dihed_pkg::RT_STEPS;

    typedef struct packed {
        logic signed [dihed_pkg::X_W-1:0] x;
        logic signed [dihed_pkg::T_W-1:0] t;
        logic [dihed_pkg::SQ_W-1:0]       rem;
        logic [dihed_pkg::RT_W-1:0]       r;
    } rt_stage_t;

    logic [NS:0] vld_reg;
    rt_stage_t   st_reg  [NS];
    rt_stage_t   st_next [NS];
    logic signed [dihed_pkg::X_W-1:0] x_reg;
    logic signed [dihed_pkg::T_W-1:0] t_reg;
    logic [dihed_pkg::RG_W-1:0]       rg_reg;
    logic [dihed_pkg::RG_W-1:0]       rg_next;

    always_comb
    begin
        rt_stage_t cur;
        logic [dihed_pkg::RT_W-1:0] bitv;
        logic [dihed_pkg::RT_W-1:0] trial;
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                cur.x   = x;
                cur.t   = t;
                cur.rem = n;
                cur.r   = '0;
            end
            else
                cur = st_reg[k-1];
            bitv  = dihed_pkg::RT_W'(1) << (2 * (NS - 1 - k));
            trial = cur.r + bitv;
            if ({1'b0, cur.rem} >= trial)
            begin
                cur.rem = cur.rem - trial[dihed_pkg::SQ_W-1:0];
                cur.r   = (cur.r >> 1) + bitv;
            end
            else
                cur.r = cur.r >> 1;
            st_next[k] = cur;
        end
    end

    // round up when the remainder exceeds the root
    always_comb
    begin
        if ({1'b0, st_reg[NS-1].rem} > st_reg[NS-1].r)
            rg_next = st_reg[NS-1].r[dihed_pkg::RG_W-1:0] + dihed_pkg::RG_W'(1);
        else
            rg_next = st_reg[NS-1].r[dihed_pkg::RG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
                st_reg[k] <= st_next[k];
            x_reg  <= st_reg[NS-1].x;
            t_reg  <= st_reg[NS-1].t;
            rg_reg <= rg_next;
        end
    end

    assign out_valid = vld_reg[NS];
    assign x_out = x_reg;
    assign t_out = t_reg;
    assign rg    = rg_reg;

endmodule

### sv/dihed_cordic.sv
// ----------------------------------------------------------------------------
// dihed_cordic
// sine term product, range normalization, quadrant fold, pipelined cordic
// vectoring and rounding to 1/256 degree
// ----------------------------------------------------------------------------
module dihed_cordic (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [dihed_pkg::X_W-1:0]      x,
    input  logic signed [dihed_pkg::T_W-1:0]      t,
    input  logic [dihed_pkg::RG_W-1:0]            rg,
    output logic                                  out_valid,
    output logic signed [dihed_pkg::ANG_W-1:0]    angle
);

    localparam int NPRE = 7;
    localparam int NCS  = dihed_pkg::CD_STEPS;
    localparam int NSTG = NPRE + NCS + 1;
    localparam int PH_W = dihed_pkg::T_W - dihed_pkg::HALF_W + dihed_pkg::RG_W + 1;
    localparam int PL_W = dihed_pkg::HALF_W + dihed_pkg::RG_W + 1;
    localparam int GRP  = dihed_pkg::X_W / 8;
    localparam int RD_W = dihed_pkg::Z_W + 1;

    typedef logic signed [dihed_pkg::CD_W-1:0] cd_t;
    typedef logic signed [dihed_pkg::Z_W-1:0]  z_t;
    typedef logic signed [dihed_pkg::X_W-1:0]  x_t;
    typedef logic signed [PH_W-1:0]            ph_t;
    typedef logic signed [RD_W-1:0]            rd_t;

    typedef struct packed {
        cd_t x;
        cd_t y;
        z_t  z;
    } cs_t;

    function automatic z_t atan_q16(input logic [4:0] i);
        z_t a;
        unique case (i)
            5'd0:    a = 27'sd2949120;
            5'd1:    a = 27'sd1740967;
            5'd2:    a = 27'sd919879;
            5'd3:    a = 27'sd466945;
            5'd4:    a = 27'sd234379;
            5'd5:    a = 27'sd117304;
            5'd6:    a = 27'sd58666;
            5'd7:    a = 27'sd29335;
            5'd8:    a = 27'sd14668;
            5'd9:    a = 27'sd7334;
            5'd10:   a = 27'sd3667;
            5'd11:   a = 27'sd1833;
            5'd12:   a = 27'sd917;
            5'd13:   a = 27'sd458;
            5'd14:   a = 27'sd229;
            5'd15:   a = 27'sd115;
            5'd16:   a = 27'sd57;
            5'd17:   a = 27'sd29;
            5'd18:   a = 27'sd14;
            5'd19:   a = 27'sd7;
            5'd20:   a = 27'sd4;
            5'd21:   a = 27'sd2;
            5'd22:   a = 27'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic [dihed_pkg::X_W-1:0] mag64(input x_t v);
        return v[dihed_pkg::X_W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic cd_t shrink(input logic [dihed_pkg::X_W-1:0] m,
                                   input logic neg,
                                   input logic [dihed_pkg::NRM_SH_W-1:0] sh);
        logic [dihed_pkg::X_W-1:0] s;
        cd_t c;
        s = m >> sh;
        c = cd_t'(s[dihed_pkg::NORM_MSB:0]);
        return neg ? -c : c;
    endfunction

    logic [NSTG-1:0] vld_reg;

    ph_t ph_reg;
    logic [PL_W-1:0] pl_reg;
    x_t x1_reg, x2_reg, y2_reg;
    logic [dihed_pkg::X_W-1:0] mx3_reg, my3_reg, mo_reg;
    logic [dihed_pkg::X_W-1:0] mx4_reg, my4_reg;
    logic [dihed_pkg::X_W-1:0] mx5_reg, my5_reg;
    logic nx3_reg, ny3_reg, nx4_reg, ny4_reg, nx5_reg, ny5_reg;
    logic [$clog2(GRP)-1:0] grp_reg, grp_next;
    logic [7:0] byt_reg;
    logic [dihed_pkg::NRM_SH_W-1:0] sh_reg, sh_next;
    cd_t xs_reg, ys_reg;
    cs_t fold_reg, fold_next;
    cs_t cs_reg  [NCS];
    cs_t cs_next [NCS];
    logic signed [dihed_pkg::ANG_W-1:0] ang_reg, ang_next;

    // highest nonzero byte of the combined magnitude
    always_comb
    begin
        grp_next = '0;
        for (int g = 0; g < GRP; g++)
        begin
            if (|mo_reg[8*g +: 8])
                grp_next = ($clog2(GRP))'(g);
        end
    end

    always_comb
    begin
        logic [dihed_pkg::NRM_SH_W-1:0] msb;
        msb = {grp_reg, 3'b000};
        for (int b = 0; b < 8; b++)
        begin
            if (byt_reg[b])
                msb = {grp_reg, 3'(b)};
        end
        if (msb > dihed_pkg::NRM_SH_W'(dihed_pkg::NORM_MSB))
            sh_next = msb - dihed_pkg::NRM_SH_W'(dihed_pkg::NORM_MSB);
        else
            sh_next = '0;
    end

    // fold the left half plane by a half turn
    always_comb
    begin
        fold_next.x = xs_reg;
        fold_next.y = ys_reg;
        fold_next.z = '0;
        if (xs_reg[dihed_pkg::CD_W-1])
        begin
            fold_next.z = ys_reg[dihed_pkg::CD_W-1] ? -dihed_pkg::DEG180_Q16
                                                    : dihed_pkg::DEG180_Q16;
            fold_next.x = -xs_reg;
            fold_next.y = -ys_reg;
        end
    end

    always_comb
    begin
        cs_t cur;
        cd_t dx;
        cd_t dy;
        for (int k = 0; k < NCS; k++)
        begin
            cur = (k == 0) ? fold_reg : cs_reg[k == 0 ? 0 : k-1];
            dx  = cur.x >>> k;
            dy  = cur.y >>> k;
            if (cur.y != '0)
            begin
                if (!cur.y[dihed_pkg::CD_W-1])
                begin
                    cur.x = cur.x + dy;
                    cur.y = cur.y - dx;
                    cur.z = cur.z + atan_q16(5'(k));
                end
                else
                begin
                    cur.x = cur.x - dy;
                    cur.y = cur.y + dx;
                    cur.z = cur.z - atan_q16(5'(k));
                end
            end
            cs_next[k] = cur;
        end
    end

    // round halves away from zero, then saturate
    always_comb
    begin
        rd_t q;
        rd_t r;
        q = rd_t'(cs_reg[NCS-1].z);
        if (!q[RD_W-1])
            r = (q + rd_t'(128)) >>> 8;
        else
            r = -((-q + rd_t'(128)) >>> 8);
        if (r > rd_t'(dihed_pkg::ANGLE_LIMIT))
            ang_next = dihed_pkg::ANGLE_LIMIT;
        else if (r < -rd_t'(dihed_pkg::ANGLE_LIMIT))
            ang_next = -dihed_pkg::ANGLE_LIMIT;
        else
            ang_next = r[dihed_pkg::ANG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg <= ph_t'($signed(t[dihed_pkg::T_W-1:dihed_pkg::HALF_W]))
                    * ph_t'($signed({1'b0, rg}));
            pl_reg <= PL_W'(t[dihed_pkg::HALF_W-1:0]) * PL_W'(rg);
            x1_reg <= x;

            y2_reg <= (x_t'(ph_reg) <<< dihed_pkg::HALF_W) + x_t'(pl_reg);
            x2_reg <= x1_reg;

            mx3_reg <= mag64(x2_reg);
            my3_reg <= mag64(y2_reg);
            nx3_reg <= x2_reg[dihed_pkg::X_W-1];
            ny3_reg <= y2_reg[dihed_pkg::X_W-1];
            mo_reg  <= mag64(x2_reg) | mag64(y2_reg);

            grp_reg <= grp_next;
            byt_reg <= mo_reg[{grp_next, 3'b000} +: 8];
            mx4_reg <= mx3_reg;
            my4_reg <= my3_reg;
            nx4_reg <= nx3_reg;
            ny4_reg <= ny3_reg;

            sh_reg  <= sh_next;
            mx5_reg <= mx4_reg;
            my5_reg <= my4_reg;
            nx5_reg <= nx4_reg;
            ny5_reg <= ny4_reg;

            xs_reg <= shrink(mx5_reg, nx5_reg, sh_reg);
            ys_reg <= shrink(my5_reg, ny5_reg, sh_reg);

            fold_reg <= fold_next;

            for (int k = 0; k < NCS; k++)
                cs_reg[k] <= cs_next[k];

            ang_reg <= ang_next;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign angle = ang_reg;

endmodule

### sv/dihedral_angle_from_four_points.sv
// ----------------------------------------------------------------------------
// dihedral_angle_from_four_points
// path: vector, cross, square root, cordic, then the output register
// throughput: one torsion per cycle while the skid slot is free, set by
//   the fully pipelined cordic, square root and multiplier stages
// reset: box lengths return to 100.0, wrap disabled on all axes, pipeline empty
// ----------------------------------------------------------------------------
module dihedral_angle_from_four_points (
    input  logic          clk,
    input  logic          rst_n,
    dihed_pts_if.sink     pts,
    dihed_angle_if.source res,
    dihed_cfg_if.sink     cfg
);

    dihed_pkg::box_cfg_t cfg_reg;
    dihed_pkg::pts_t     pts_word;
    logic                adv;

    logic                 v_vec, v_crs, v_rt, v_cd;
    dihed_pkg::svec_t     b1, b2, b3;
    logic signed [dihed_pkg::X_W-1:0] x_crs, x_rt;
    logic signed [dihed_pkg::T_W-1:0] t_crs, t_rt;
    logic [dihed_pkg::SQ_W-1:0]       n_crs;
    logic [dihed_pkg::RG_W-1:0]       rg;
    logic signed [dihed_pkg::ANG_W-1:0] ang;

    logic outv_reg, skv_reg;
    logic signed [dihed_pkg::ANG_W-1:0] outd_reg, skd_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_x <= dihed_pkg::BOX_RESET;
            cfg_reg.box_y <= dihed_pkg::BOX_RESET;
            cfg_reg.box_z <= dihed_pkg::BOX_RESET;
            cfg_reg.axes  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (dihed_pkg::cfg_reg_e'(cfg.index))
                dihed_pkg::REG_BOX_X: cfg_reg.box_x <= cfg.data;
                dihed_pkg::REG_BOX_Y: cfg_reg.box_y <= cfg.data;
                dihed_pkg::REG_BOX_Z: cfg_reg.box_z <= cfg.data;
                dihed_pkg::REG_AXES:  cfg_reg.axes  <= cfg.data[dihed_pkg::AXES_W-1:0];
            endcase
        end
    end

    assign pts_word.p1.x = pts.p1_x;
    assign pts_word.p1.y = pts.p1_y;
    assign pts_word.p1.z = pts.p1_z;
    assign pts_word.p2.x = pts.p2_x;
    assign pts_word.p2.y = pts.p2_y;
    assign pts_word.p2.z = pts.p2_z;
    assign pts_word.p3.x = pts.p3_x;
    assign pts_word.p3.y = pts.p3_y;
    assign pts_word.p3.z = pts.p3_z;
    assign pts_word.p4.x = pts.p4_x;
    assign pts_word.p4.y = pts.p4_y;
    assign pts_word.p4.z = pts.p4_z;

    // pipeline moves whenever the skid slot is free
    assign adv       = !skv_reg;
    assign pts.ready = adv;

    dihed_vec u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pts.valid),
        .pts       (pts_word),
        .cfg       (cfg_reg),
        .out_valid (v_vec),
        .b1        (b1),
        .b2        (b2),
        .b3        (b3)
    );

    dihed_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_vec),
        .b1        (b1),
        .b2        (b2),
        .b3        (b3),
        .out_valid (v_crs),
        .x         (x_crs),
        .t         (t_crs),
        .n         (n_crs)
    );

    dihed_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_crs),
        .x         (x_crs),
        .t         (t_crs),
        .n         (n_crs),
        .out_valid (v_rt),
        .x_out     (x_rt),
        .t_out     (t_rt),
        .rg        (rg)
    );

    dihed_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_rt),
        .x         (x_rt),
        .t         (t_rt),
        .rg        (rg),
        .out_valid (v_cd),
        .angle     (ang)
    );

    // output register with one skid word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outv_reg <= 1'b0;
            skv_reg  <= 1'b0;
        end
        else if (skv_reg)
        begin
            if (res.ready)
                skv_reg <= 1'b0;
        end
        else if (!outv_reg || res.ready)
            outv_reg <= v_cd;
        else if (v_cd)
            skv_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skv_reg)
        begin
            if (res.ready)
                outd_reg <= skd_reg;
        end
        else if (!outv_reg || res.ready)
            outd_reg <= ang;
        else
            skd_reg <= ang;
    end

    assign res.valid     = outv_reg;
    assign res.angle_deg = outd_reg;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skv_reg |-> outv_reg)
        else $error("skid word held while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skv_reg) |-> $past(outv_reg && !res.ready))
        else $error("skid filled without an output stall");

    a_skid_drain_order: assert property (@(posedge clk) disable iff (!rst_n)
        skv_reg && res.ready |=> outv_reg && (outd_reg == $past(skd_reg)))
        else $error("skid word not moved to output in order");
`endif

endmodule
